@@ design/stq_pkg.sv @@
package stq_pkg;

  // Width of one stored end time.
  localparam int TIME_W = 24;

  // Width of the reported entry count.
  localparam int COUNT_W = 5;

  // Default number of cells in the chain.
  localparam int DEPTH_DEF = 16;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Request actions.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  // One input request.
  typedef struct packed {
    logic              action;
    logic [TIME_W-1:0] time_value;
  } in_t;

  // One result.
  typedef struct packed {
    status_t            status;
    logic [TIME_W-1:0]  head_time;
    logic               head_valid;
    logic [COUNT_W-1:0] entry_count;
  } out_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic              shift_ins;
    logic              shift_del;
    logic [TIME_W-1:0] t;
  } cell_cmd_t;

endpackage

@@ design/stq_cell.sv @@
module stq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                      clk,
  input  stq_pkg::cell_cmd_t        cmd,
  input  logic [CNT_W-1:0]          count,
  input  logic                      left_ins,
  input  logic [stq_pkg::TIME_W-1:0] left_data,
  input  logic [stq_pkg::TIME_W-1:0] right_data,
  output logic                      ins,
  output logic [stq_pkg::TIME_W-1:0] data_q,
  output logic [stq_pkg::TIME_W-1:0] data_nxt
);
  import stq_pkg::*;

  logic [TIME_W-1:0] data_r;
  logic              occ;

  // A cell is occupied when its place lies below the current count.
  assign occ = CNT_W'(IDX) < count;

  // The new time goes at or before this cell when the cell is free or
  // holds a strictly greater time.
  assign ins = !occ || (data_r > cmd.t);

  // Insert shifts greater entries one place up; delete shifts all down.
  always_comb begin
    data_nxt = data_r;
    if (cmd.shift_ins && ins) begin
      data_nxt = left_ins ? left_data : cmd.t;
    end else if (cmd.shift_del) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

@@ design/sorted_time_queue.sv @@
// Sorted queue of 24-bit end times held in a chain of DEPTH cells, smallest
// time in cell 0. For each request (insert, or delete of the head when it
// matches the given time) every cell compares its time with the request in
// parallel and the chain shifts up or down in a single step, so a new
// request is accepted in every cycle in which the registered result is
// free or being taken. Each request gives exactly one result with a status,
// the head and the count after the request. An insert into a full queue and a
// delete on an empty queue leave the queue unchanged and are flagged. After
// reset the queue is empty and ready at once; there is no clearing pass.
module sorted_time_queue #(
  parameter int DEPTH = stq_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  stq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output stq_pkg::out_t out_data
);
  import stq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r;
  out_t              out_r;
  cell_cmd_t         cmd;
  logic              accept, full, empty, head_match;
  status_t           status;
  logic [TIME_W-1:0] data_q   [DEPTH];
  logic [TIME_W-1:0] data_nxt [DEPTH];
  logic              ins_chain [DEPTH+1];

  // A request is taken when no result is waiting or it is being taken.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign full       = count_r == CNT_W'(DEPTH);
  assign empty      = count_r == '0;
  assign head_match = data_q[0] == in_data.time_value;

  // Decide the status and the chain command.
  always_comb begin
    cmd.t         = in_data.time_value;
    cmd.shift_ins = 1'b0;
    cmd.shift_del = 1'b0;
    count_nxt     = count_r;
    if (in_data.action == ACT_INSERT) begin
      status = full ? ST_FULL : ST_OK;
      if (accept && !full) begin
        cmd.shift_ins = 1'b1;
        count_nxt     = count_r + 1'b1;
      end
    end else begin
      if (empty) begin
        status = ST_EMPTY;
      end else if (!head_match) begin
        status = ST_MISMATCH;
      end else begin
        status = ST_OK;
        if (accept) begin
          cmd.shift_del = 1'b1;
          count_nxt     = count_r - 1'b1;
        end
      end
    end
  end

  // Chain of cells; the insert flag ripples from each cell to the next.
  assign ins_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [TIME_W-1:0] left_d, right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid
      assign left_d = data_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = data_q[i];
    end else begin : g_inner
      assign right_d = data_q[i+1];
    end

    stq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .left_ins   (ins_chain[i]),
      .left_data  (left_d),
      .right_data (right_d),
      .ins        (ins_chain[i+1]),
      .data_q     (data_q[i]),
      .data_nxt   (data_nxt[i])
    );
  end

  // Count and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, built from the state after the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r.status      <= status;
      out_r.head_time   <= (count_nxt != '0) ? data_nxt[0] : '0;
      out_r.head_valid  <= count_nxt != '0;
      out_r.entry_count <= COUNT_W'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // An accepted insert into a non-full queue adds one entry.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.action == ACT_INSERT && !full
      |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the queue");

  // A matching delete removes one entry.
  a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.action == ACT_DELETE && !empty && head_match
      |=> count_r == $past(count_r) - 1'b1)
    else $error("delete did not shrink the queue");

  // The two lowest cells stay in ascending order.
  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(2) |-> data_q[0] <= data_q[1])
    else $error("head cells out of order");

endmodule
